// ----- hdl/rsg_pkg.sv -----
// rsg_pkg: shared widths, codes and types of the risky safe gap block
// no dependencies; used by every other file of the block but rsg_if
package rsg_pkg;

   localparam int SPEED_W     = 16;
   localparam int BRAKE_W     = 12;
   localparam int OFFSET_W    = 24;
   localparam int GAP_W       = 32;
   localparam int CASE_W      = 2;
   localparam int CSR_INDEX_W = 2;

   // signed numerator, its magnitude and the divisor of the gap quotient
   localparam int NUM_W = 48;
   localparam int MAG_W = NUM_W - 1;
   localparam int DEN_W = 2 * BRAKE_W + 1;

   localparam int RSG_QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_OFFSET   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_OFFSET = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RISK_SPEED   = 2'd2;

   typedef enum logic [CASE_W-1:0] {
      CASE_STOP  = 2'd0,
      CASE_BRAKE = 2'd1,
      CASE_ZERO  = 2'd2
   } gap_case_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_offset;
      logic [SPEED_W-1:0] risk_speed;
   } rsg_front_cfg_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic [DEN_W-1:0] den;
      logic             neg;
      logic             force_max;
      gap_case_type     gcase;
   } rsg_work_type;

endpackage

// ----- hdl/rsg_if.sv -----
// rsg_req_if, rsg_rsp_if: request and result channels of the block
// depend on nothing; field widths follow the block's fixed formats
interface rsg_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] follower_speed;
   logic [15:0] leader_speed;
   logic [11:0] follower_brake;
   logic [11:0] leader_brake;

   modport source (output valid, follower_speed, leader_speed, follower_brake,
                   leader_brake, input ready);
   modport sink (input valid, follower_speed, leader_speed, follower_brake,
                 leader_brake, output ready);
endinterface

interface rsg_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] gap;
   logic [1:0]  gap_case;
   logic        saturated;

   modport source (output valid, gap, gap_case, saturated, input ready);
   modport sink (input valid, gap, gap_case, saturated, output ready);
endinterface

// ----- hdl/rsg_front.sv -----
// rsg_front: accepts requests, forms products, classifies the case and
// builds numerator and divisor; depends on rsg_pkg and rsg_req_if
module rsg_front import rsg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   rsg_req_if.sink           req,
   input  rsg_front_cfg_type cfg,
   input  logic              q_full,
   output logic              push,
   output rsg_work_type      work
);

   typedef struct packed {
      logic [28:0]        pf;
      logic [27:0]        pl;
      logic [33:0]        sq_xf;
      logic [31:0]        sq_vl;
      logic [33:0]        sq_d;
      logic [31:0]        r2;
      logic [BRAKE_W-1:0] bf;
      logic [BRAKE_W-1:0] bl;
   } s1_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] m1;
      logic [NUM_W-1:0]        m2;
      logic signed [NUM_W-1:0] nc1;
      logic [23:0]             den0;
      logic [BRAKE_W-1:0]      diff;
      logic                    force_max;
      gap_case_type            gcase;
   } s2_type;

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   logic   v1_ff, v2_ff;
   logic   en;

   logic [16:0]             xf;
   logic signed [17:0]      d;
   logic [16:0]             d_abs;
   logic signed [34:0]      n1;
   logic signed [35:0]      nc;
   logic                    ge;
   logic signed [NUM_W-1:0] num;

   assign en        = !(v2_ff && q_full);
   assign req.ready = en;
   assign push      = v2_ff && en;

   always_comb begin
      xf    = {1'b0, req.follower_speed} + {1'b0, cfg.speed_offset};
      d     = $signed({2'b0, req.follower_speed}) - $signed({2'b0, req.leader_speed})
              + $signed({2'b0, cfg.speed_offset});
      d_abs = d[17] ? 17'(-d) : d[16:0];
      s1_in.pf    = 29'(xf) * 29'(req.leader_brake);
      s1_in.pl    = 28'(req.leader_speed) * 28'(req.follower_brake);
      s1_in.sq_xf = 34'(xf) * 34'(xf);
      s1_in.sq_vl = 32'(req.leader_speed) * 32'(req.leader_speed);
      s1_in.sq_d  = 34'(d_abs) * 34'(d_abs);
      s1_in.r2    = 32'(cfg.risk_speed) * 32'(cfg.risk_speed);
      s1_in.bf    = req.follower_brake;
      s1_in.bl    = req.leader_brake;
   end

   always_comb begin
      n1 = $signed({1'b0, s1_ff.sq_xf}) - $signed({3'b0, s1_ff.r2});
      nc = $signed({2'b0, s1_ff.sq_d}) - $signed({4'b0, s1_ff.r2});
      ge = {1'b0, s1_ff.pf} >= {2'b0, s1_ff.pl};
      s2_in.m1   = NUM_W'(n1) * $signed({{(NUM_W-BRAKE_W){1'b0}}, s1_ff.bl});
      s2_in.m2   = NUM_W'(s1_ff.sq_vl) * NUM_W'(s1_ff.bf);
      s2_in.nc1  = NUM_W'(nc);
      s2_in.den0 = 24'(s1_ff.bf) * 24'(s1_ff.bl);
      s2_in.diff = s1_ff.bf - s1_ff.bl;
      s2_in.force_max = ge && (s1_ff.bf == '0 || s1_ff.bl == '0);
      if (ge) begin
         s2_in.gcase = CASE_STOP;
      end else if (s1_ff.bf > s1_ff.bl) begin
         s2_in.gcase = CASE_BRAKE;
      end else begin
         s2_in.gcase = CASE_ZERO;
      end
   end

   always_comb begin
      if (s2_ff.gcase == CASE_STOP) begin
         num      = s2_ff.m1 - $signed(s2_ff.m2);
         work.den = {s2_ff.den0, 1'b0};
      end else begin
         num      = s2_ff.nc1;
         work.den = {{(DEN_W-BRAKE_W-1){1'b0}}, s2_ff.diff, 1'b0};
      end
      work.neg       = num[NUM_W-1];
      work.mag       = num[NUM_W-1] ? ~num[MAG_W-1:0] : num[MAG_W-1:0];
      work.force_max = s2_ff.force_max;
      work.gcase     = s2_ff.gcase;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
      end
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

endmodule

// ----- hdl/rsg_queue.sv -----
// rsg_queue: short fifo of classified work between front and back
// depends on rsg_pkg for the work type
module rsg_queue import rsg_pkg::*; #(
   parameter int DEPTH = RSG_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsg_work_type wdata,
   input  logic         pop,
   output rsg_work_type rdata,
   output logic         full,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   rsg_work_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = count_ff == CNT_W'(DEPTH);
   assign empty = count_ff == '0;
   assign rdata = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

// ----- hdl/rsg_back.sv -----
// rsg_back: pipelined restoring divider, floor rounding, offset and clipping
// depends on rsg_pkg and rsg_rsp_if
module rsg_back import rsg_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  rsg_work_type               head,
   input  logic                       q_empty,
   output logic                       pop,
   input  logic signed [OFFSET_W-1:0] gap_offset,
   rsg_rsp_if.source                  rsp
);

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [MAG_W-1:0] nq;
      logic [DEN_W-1:0] den;
      logic             neg;
      logic             force_max;
      gap_case_type     gcase;
   } stage_type;

   function automatic stage_type div_step(stage_type s);
      logic [DEN_W:0] t;
      stage_type      r;
      r = s;
      t = {s.rem, s.nq[MAG_W-1]};
      if (t >= {1'b0, s.den}) begin
         t    = t - {1'b0, s.den};
         r.nq = {s.nq[MAG_W-2:0], 1'b1};
      end else begin
         r.nq = {s.nq[MAG_W-2:0], 1'b0};
      end
      r.rem = t[DEN_W-1:0];
      return r;
   endfunction

   stage_type            st_ff [MAG_W+1];
   logic [MAG_W:0]       sv_ff;
   logic                 en;
   stage_type            st0_in;
   stage_type            last;
   logic [NUM_W-1:0]     q;
   logic [NUM_W:0]       sum;
   logic                 over;
   logic                 out_valid_ff;
   logic [GAP_W-1:0]     gap_ff, gap_in;
   gap_case_type         case_ff;
   logic                 sat_ff, sat_in;

   assign en  = !(out_valid_ff && !rsp.ready);
   assign pop = en && !q_empty;

   always_comb begin
      st0_in.rem       = '0;
      st0_in.nq        = head.mag;
      st0_in.den       = head.den;
      st0_in.neg       = head.neg;
      st0_in.force_max = head.force_max;
      st0_in.gcase     = head.gcase;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= '0;
      end else if (en) begin
         sv_ff <= {sv_ff[MAG_W-1:0], pop};
      end
      if (en) begin
         st_ff[0] <= st0_in;
         for (int k = 0; k < MAG_W; k++) begin
            st_ff[k+1] <= div_step(st_ff[k]);
         end
      end
   end

   always_comb begin
      last = st_ff[MAG_W];
      q    = last.neg ? ~{1'b0, last.nq} : {1'b0, last.nq};
      sum  = {q[NUM_W-1], q} + {{(NUM_W+1-OFFSET_W){gap_offset[OFFSET_W-1]}}, gap_offset};
      over = !((&sum[NUM_W:GAP_W-1]) || !(|sum[NUM_W:GAP_W-1]));
      if (last.force_max) begin
         gap_in = {1'b0, {(GAP_W-1){1'b1}}};
         sat_in = 1'b1;
      end else if (last.gcase == CASE_ZERO) begin
         gap_in = '0;
         sat_in = 1'b0;
      end else if (over) begin
         gap_in = sum[NUM_W] ? {1'b1, {(GAP_W-1){1'b0}}} : {1'b0, {(GAP_W-1){1'b1}}};
         sat_in = 1'b1;
      end else begin
         gap_in = sum[GAP_W-1:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= sv_ff[MAG_W];
      end
      if (en) begin
         gap_ff  <= gap_in;
         case_ff <= last.gcase;
         sat_ff  <= sat_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.gap       = gap_ff;
   assign rsp.gap_case  = case_ff;
   assign rsp.saturated = sat_ff;

endmodule

// ----- hdl/risky_safe_gap.sv -----
// risky_safe_gap: top level, configuration registers and the three parts
// depends on rsg_pkg, rsg_if, rsg_front, rsg_queue and rsg_back
//
// Takes one vehicle pair per clock unless the queue is full and returns one
// gap result per pair, in order. A pair passes the front stages that multiply
// and classify, the work queue, then a 47-stage restoring divider that
// resolves one quotient bit per stage, and the output register. A stalled
// result holds the divider; the front keeps accepting requests until the
// queue of QUEUE_DEPTH entries fills. Write configuration only while no
// request is in flight.
module risky_safe_gap import rsg_pkg::*; #(
   parameter int QUEUE_DEPTH = RSG_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   rsg_req_if.sink                req,
   rsg_rsp_if.source              rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [OFFSET_W-1:0]    csr_wdata
);

   logic [OFFSET_W-1:0] gap_offset_ff;
   logic [SPEED_W-1:0]  speed_offset_ff;
   logic [SPEED_W-1:0]  risk_speed_ff;
   rsg_front_cfg_type   front_cfg;
   rsg_work_type        q_wdata, q_rdata;
   logic                q_push, q_pop, q_full, q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_offset_ff   <= '0;
         speed_offset_ff <= '0;
         risk_speed_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAP_OFFSET:   gap_offset_ff   <= csr_wdata;
            CSR_SPEED_OFFSET: speed_offset_ff <= csr_wdata[SPEED_W-1:0];
            CSR_RISK_SPEED:   risk_speed_ff   <= csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   assign front_cfg.speed_offset = speed_offset_ff;
   assign front_cfg.risk_speed   = risk_speed_ff;

   rsg_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .cfg    (front_cfg),
      .q_full (q_full),
      .push   (q_push),
      .work   (q_wdata)
   );

   rsg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   rsg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_rdata),
      .q_empty    (q_empty),
      .pop        (q_pop),
      .gap_offset ($signed(gap_offset_ff)),
      .rsp        (rsp)
   );

`ifndef SYNTHESIS
   a_zero_case: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.gap_case == CASE_ZERO |-> rsp.gap == '0 && !rsp.saturated)
      else $error("zero case with nonzero gap");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.saturated |->
         rsp.gap == 32'h7fff_ffff || rsp.gap == 32'h8000_0000)
      else $error("saturated gap not at a bound");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      q_full && !q_pop |-> !q_push)
      else $error("push into a full queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from an empty queue");
`endif

endmodule

// ----- tb/rsg_gap_book.sv -----
// rsg_gap_book: scoreboard class that predicts and checks gap results
// depends on rsg_pkg for the case codes and the register codes
`timescale 1ns / 100ps

import rsg_pkg::*;

class rsg_gap_book;

   logic signed [23:0] gap_offset;
   logic [15:0]        speed_offset;
   logic [15:0]        risk_speed;
   logic [31:0]        gap_q[$];
   gap_case_type       case_q[$];
   logic               sat_q[$];
   int                 errors;

   function new();
      gap_offset = 0;
      speed_offset = 0;
      risk_speed = 0;
      errors = 0;
   endfunction

   function void set_reg(logic [1:0] index, logic [23:0] value);
      if (index == CSR_GAP_OFFSET) gap_offset = value;
      else if (index == CSR_SPEED_OFFSET) speed_offset = value[15:0];
      else if (index == CSR_RISK_SPEED) risk_speed = value[15:0];
   endfunction

   function longint floor_quot(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
   endfunction

   function void note_request(logic [15:0] vf, logic [15:0] vl,
                              logic [11:0] bf, logic [11:0] bl);
      longint xf, r2, g, d;
      gap_case_type c;
      logic sat;
      xf = longint'(vf) + longint'(speed_offset);
      r2 = longint'(risk_speed) * longint'(risk_speed);
      g = 0;
      sat = 0;
      if (xf * bl >= longint'(vl) * bf) begin
         c = CASE_STOP;
         if (bf == 0 || bl == 0) begin
            g = 64'sd2147483647;
            sat = 1;
         end else begin
            g = floor_quot((xf * xf - r2) * bl - longint'(vl) * vl * bf,
                           2 * longint'(bf) * bl) + gap_offset;
         end
      end else if (bf > bl) begin
         c = CASE_BRAKE;
         d = longint'(vf) - longint'(vl) + longint'(speed_offset);
         g = floor_quot(d * d - r2, 2 * (longint'(bf) - bl)) + gap_offset;
      end else begin
         c = CASE_ZERO;
      end
      if (g > 64'sd2147483647) begin
         g = 64'sd2147483647;
         sat = 1;
      end else if (g < -64'sd2147483648) begin
         g = -64'sd2147483648;
         sat = 1;
      end
      gap_q.push_back(g[31:0]);
      case_q.push_back(c);
      sat_q.push_back(sat);
   endfunction

   function void check_result(logic [31:0] gap, logic [1:0] gc, logic sat);
      if (gap_q.size() == 0) begin
         $display("%0t unexpected result gap=%h case=%0d sat=%b", $time, gap, gc, sat);
         errors++;
         return;
      end
      if (gap !== gap_q[0] || gc !== case_q[0] || sat !== sat_q[0]) begin
         $display("%0t mismatch expected gap=%h case=%0d sat=%b actual gap=%h case=%0d sat=%b",
                  $time, gap_q[0], case_q[0], sat_q[0], gap, gc, sat);
         errors++;
      end
      void'(gap_q.pop_front());
      void'(case_q.pop_front());
      void'(sat_q.pop_front());
   endfunction

   function int pending();
      return gap_q.size();
   endfunction
endclass

// ----- tb/testbench.sv -----
// testbench: drives risky_safe_gap with directed and random requests
// depends on rsg_pkg, rsg_if, rsg_gap_book and the block itself
`timescale 1ns / 100ps

module testbench;
   import rsg_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [1:0]  csr_index = CSR_GAP_OFFSET;
   logic [23:0] csr_wdata = 0;
   logic        sending = 1;
   int          rsp_count = 0;
   int          rsp_seen = 0;
   int          rsp_wait = 0;

   rsg_req_if req ();
   rsg_rsp_if rsp ();

   rsg_gap_book book = new();

   risky_safe_gap dut (.clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
                       .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   initial begin
      req.valid = 0;
      req.follower_speed = 0;
      req.leader_speed = 0;
      req.follower_brake = 0;
      req.leader_brake = 0;
      rsp.ready = 0;
   end

   task automatic write_reg(logic [1:0] index, logic [23:0] value);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 0;
      book.set_reg(index, value);
   endtask

   task automatic send_pair(logic [15:0] vf, logic [15:0] vl, logic [11:0] bf,
                            logic [11:0] bl, bit idle);
      int wait_n;
      wait_n = idle ? $urandom_range(0, 7) : 0;
      repeat (wait_n) begin
         req.valid <= 0;
         @(negedge clock);
      end
      req.valid <= 1;
      req.follower_speed <= vf;
      req.leader_speed <= vl;
      req.follower_brake <= bf;
      req.leader_brake <= bl;
      do @(posedge clock); while (!req.ready);
      book.note_request(vf, vl, bf, bl);
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (book.pending() > 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic random_block(int count, bit idle);
      logic [15:0] vf, vl;
      logic [11:0] bf, bl;
      for (int i = 0; i < count; i++) begin
         vf = $urandom;
         vl = $urandom;
         bf = $urandom_range(1, 4095);
         bl = $urandom_range(1, 4095);
         case ($urandom_range(0, 5))
            0: begin
               vf = $urandom_range(0, 255);
               vl = $urandom_range(0, 255);
            end
            1: bf = $urandom_range(0, 3) == 0 ? 12'd0 : 12'hfff;
            2: bl = $urandom_range(0, 3) == 0 ? 12'd0 : 12'd1;
            default: ;
         endcase
         send_pair(vf, vl, bf, bl, idle);
      end
   endtask

   // random ready delay after each result on the result side, only while sending is set
   always @(negedge clock) begin
      if (rsp_seen != rsp_count) begin
         rsp_seen = rsp_count;
         rsp_wait = sending ? $urandom_range(0, 7) : 0;
      end
      if (rsp_wait > 0) begin
         rsp.ready <= 1'b0;
         rsp_wait = rsp_wait - 1;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         book.check_result(rsp.gap, rsp.gap_case, rsp.saturated);
         rsp_count = rsp_count + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_pair(16'h0000, 16'h0000, 12'h001, 12'h001, 0);
      send_pair(16'hffff, 16'h0000, 12'h001, 12'hfff, 0);
      send_pair(16'h0000, 16'hffff, 12'hfff, 12'h001, 0);
      send_pair(16'h0100, 16'h1000, 12'h800, 12'h100, 0);
      send_pair(16'h0100, 16'h1000, 12'h100, 12'h800, 0);
      send_pair(16'h1000, 16'h1000, 12'h0ff, 12'h0ff, 0);
      send_pair(16'h1234, 16'h0000, 12'h000, 12'h100, 0);
      send_pair(16'h1234, 16'h0010, 12'h100, 12'h000, 0);
      send_pair(16'hffff, 16'hffff, 12'hfff, 12'hfff, 0);
      send_pair(16'h0000, 16'h0001, 12'h000, 12'h000, 0);
      drain();

      write_reg(CSR_GAP_OFFSET, 24'h800000);
      write_reg(CSR_SPEED_OFFSET, 16'hffff);
      write_reg(CSR_RISK_SPEED, 16'hffff);
      send_pair(16'hffff, 16'hffff, 12'h001, 12'h001, 0);
      send_pair(16'h0000, 16'hffff, 12'h001, 12'hfff, 0);
      send_pair(16'h0000, 16'h0000, 12'h002, 12'h001, 0);
      random_block(100, 1);
      drain();

      write_reg(CSR_GAP_OFFSET, 24'h7fffff);
      write_reg(CSR_SPEED_OFFSET, 16'h0000);
      write_reg(CSR_RISK_SPEED, 16'h0000);
      send_pair(16'hffff, 16'h0000, 12'h001, 12'hfff, 0);
      random_block(400, 1);
      drain();

      for (int p = 0; p < 4; p++) begin
         write_reg(CSR_GAP_OFFSET, $urandom_range(0, 1) ? 24'h0 : 24'($urandom));
         write_reg(CSR_SPEED_OFFSET, $urandom_range(0, 1) ? 16'($urandom_range(0, 511))
                                                          : 16'($urandom));
         write_reg(CSR_RISK_SPEED, 16'($urandom));
         random_block(130, p != 1);
         drain();
      end

      write_reg(CSR_GAP_OFFSET, 24'h000000);
      sending = 0;
      random_block(500, 0);
      drain();

      if (book.errors == 0 && book.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
